### rtl/tcrq_pkg.sv
// Package: request and status codes for the tick credit run queue.
`timescale 1ns / 1ps

package tcrq_pkg;

  typedef enum logic [1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_PICK = 2'd2,
    FUNC_SET  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOREFILL = 2'd2,
    STAT_BAD      = 2'd3
  } status_t;

  localparam int ID_W   = 4;
  localparam int TICK_W = 8;

endpackage

### rtl/tcrq_if.sv
// Interfaces: request and response channels of the tick credit run queue.
`timescale 1ns / 1ps

interface tcrq_in_if import tcrq_pkg::*; ;
  logic              valid;
  logic              ready;
  func_t             func;
  logic [ID_W-1:0]   task_id;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] task_priority;

  modport source (output valid, func, task_id, tick_count, task_priority, input ready);
  modport sink   (input valid, func, task_id, tick_count, task_priority, output ready);
endinterface

interface tcrq_out_if import tcrq_pkg::*; ;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ID_W-1:0]   next_task;
  logic [TICK_W-1:0] next_ticks;
  logic              refilled;

  modport source (output valid, status, next_task, next_ticks, refilled, input ready);
  modport sink   (input valid, status, next_task, next_ticks, refilled, output ready);
endinterface

### rtl/tick_credit_run_queue.sv
// Top level: tick credit run queue with a slot table held in one memory.
// Usage:
//   req carries one request word (enqueue, dequeue, pick, set ticks); it is
//   taken when req.valid and req.ready are high at a clock edge. rsp returns
//   exactly one response word per request, in order.
//   One request is in work at a time; req.ready is high only while idle.
//   A rejected request or an empty pick goes straight to the response; set
//   ticks reads its slot and writes it back; enqueue makes one pass over the
//   slot memory, dequeue reads its slot and then makes one pass, and a pick
//   makes one pass, or two when it reloads ticks from priorities. Each pass
//   walks the slot memory one entry a cycle through its single read and
//   single write port. req.ready returns with rsp.valid.
//   The response sits in an output register; while rsp.ready is low the next
//   request is still taken and worked, and its response waits until the
//   output register frees.
//   rst (synchronous) clears the slot valid bits and the handshake state;
//   the slot memory needs no clearing, invalid slots are never used.
`timescale 1ns / 1ps

module tick_credit_run_queue import tcrq_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int TICK_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  tcrq_in_if.sink     req,
  tcrq_out_if.source  rsp
);

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int WORD_W = IDX_W + 2 * TICK_BITS;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_TASKS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  logic [WORD_W-1:0] mem [MAX_TASKS];
  logic [WORD_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  state_t                state, state_next;
  func_t                 op, op_next;
  logic [IDX_W-1:0]      slot, slot_next;
  logic [IDX_W-1:0]      age, age_next;
  logic [TICK_BITS-1:0]  tk_in, tk_in_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic                  rd_pend;
  logic [IDX_W-1:0]      rd_idx;
  logic [MAX_TASKS-1:0]  valid_bits, valid_bits_next;
  logic                  refill_pass, refill_pass_next;
  logic                  found, found_next;
  logic [TICK_BITS-1:0]  bt, bt_next;
  logic [IDX_W-1:0]      ba, ba_next;
  logic [IDX_W-1:0]      bidx, bidx_next;
  logic                  any_pr, any_pr_next;

  status_t           res_status, res_status_next;
  logic [ID_W-1:0]   res_task, res_task_next;
  logic [TICK_W-1:0] res_ticks, res_ticks_next;
  logic              res_refl, res_refl_next;

  logic              out_valid;
  status_t           out_status;
  logic [ID_W-1:0]   out_task;
  logic [TICK_W-1:0] out_ticks;
  logic              out_refl;

  logic                 issue;
  logic                 accept;
  logic                 id_ok;
  logic [IDX_W-1:0]     req_slot;
  logic [TICK_BITS-1:0] w_tk, w_pr, cand_t;
  logic [IDX_W-1:0]     w_rec;
  logic                 cur_v;
  logic                 load_out;

  assign w_tk   = rd_data[TICK_BITS-1:0];
  assign w_pr   = rd_data[2*TICK_BITS-1:TICK_BITS];
  assign w_rec  = rd_data[WORD_W-1:2*TICK_BITS];
  assign cur_v  = valid_bits[rd_idx];
  assign cand_t = refill_pass ? w_pr : w_tk;

  assign issue    = (state == S_SWEEP) && (cnt != CNT_END);
  assign accept   = req.valid && req.ready;
  assign id_ok    = 32'(req.task_id) < MAX_TASKS;
  assign req_slot = IDX_W'(req.task_id);
  assign rd_addr  = (state == S_SWEEP) ? cnt[IDX_W-1:0] : req_slot;
  assign load_out = (state == S_DONE) && (!out_valid || rsp.ready);

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.next_task  = out_task;
  assign rsp.next_ticks = out_ticks;
  assign rsp.refilled   = out_refl;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next       = state;
    op_next          = op;
    slot_next        = slot;
    age_next         = age;
    tk_in_next       = tk_in;
    cnt_next         = cnt;
    valid_bits_next  = valid_bits;
    refill_pass_next = refill_pass;
    found_next       = found;
    bt_next          = bt;
    ba_next          = ba;
    bidx_next        = bidx;
    any_pr_next      = any_pr;
    res_status_next  = res_status;
    res_task_next    = res_task;
    res_ticks_next   = res_ticks;
    res_refl_next    = res_refl;
    wr_en            = 1'b0;
    wr_addr          = rd_idx;
    wr_data          = rd_data;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next          = req.func;
          slot_next        = req_slot;
          tk_in_next       = TICK_BITS'(req.tick_count);
          cnt_next         = '0;
          refill_pass_next = 1'b0;
          found_next       = 1'b0;
          any_pr_next      = 1'b0;
          res_status_next  = STAT_OK;
          res_task_next    = '0;
          res_ticks_next   = '0;
          res_refl_next    = 1'b0;
          if (req.func == FUNC_PICK) begin
            if (valid_bits == '0) begin
              res_status_next = STAT_EMPTY;
              state_next      = S_DONE;
            end else begin
              state_next = S_SWEEP;
            end
          end else if (!id_ok) begin
            res_status_next = STAT_BAD;
            state_next      = S_DONE;
          end else if (req.func == FUNC_ENQ) begin
            if (valid_bits[req_slot]) begin
              res_status_next = STAT_BAD;
              state_next      = S_DONE;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = req_slot;
              wr_data    = {IDX_W'(0), TICK_BITS'(req.task_priority),
                            TICK_BITS'(req.tick_count)};
              state_next = S_SWEEP;
            end
          end else begin
            if (!valid_bits[req_slot]) begin
              res_status_next = STAT_BAD;
              state_next      = S_DONE;
            end else begin
              state_next = S_READ;
            end
          end
        end
      end

      S_READ: begin
        if (op == FUNC_DEQ) begin
          age_next              = w_rec;
          valid_bits_next[slot] = 1'b0;
          state_next            = S_SWEEP;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = slot;
          wr_data    = {w_rec, w_pr, tk_in};
          state_next = S_DONE;
        end
      end

      S_SWEEP: begin
        if (issue) begin
          cnt_next = cnt + CNT_W'(1);
        end
        if (rd_pend && cur_v) begin
          case (op)
            FUNC_ENQ: begin
              wr_en   = 1'b1;
              wr_data = {w_rec + IDX_W'(1), w_pr, w_tk};
            end
            FUNC_DEQ: begin
              if (w_rec > age) begin
                wr_en   = 1'b1;
                wr_data = {w_rec - IDX_W'(1), w_pr, w_tk};
              end
            end
            default: begin
              if (refill_pass) begin
                wr_en   = 1'b1;
                wr_data = {w_rec, w_pr, w_pr};
                if (w_pr != '0) begin
                  any_pr_next = 1'b1;
                end
              end
              if (!found || cand_t > bt || (cand_t == bt && w_rec < ba)) begin
                found_next = 1'b1;
                bt_next    = cand_t;
                ba_next    = w_rec;
                bidx_next  = rd_idx;
              end
            end
          endcase
        end
        if (rd_pend && !issue) begin
          case (op)
            FUNC_ENQ: begin
              valid_bits_next[slot] = 1'b1;
              state_next            = S_DONE;
            end
            FUNC_DEQ: begin
              state_next = S_DONE;
            end
            default: begin
              if (!refill_pass && bt_next == '0) begin
                refill_pass_next = 1'b1;
                found_next       = 1'b0;
                any_pr_next      = 1'b0;
                cnt_next         = '0;
              end else if (refill_pass && !any_pr_next) begin
                res_status_next = STAT_NOREFILL;
                state_next      = S_DONE;
              end else begin
                res_task_next  = ID_W'(bidx_next);
                res_ticks_next = TICK_W'(bt_next);
                res_refl_next  = refill_pass;
                state_next     = S_DONE;
              end
            end
          endcase
        end
      end

      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      valid_bits <= valid_bits_next;
      rd_pend    <= issue;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    slot        <= slot_next;
    age         <= age_next;
    tk_in       <= tk_in_next;
    cnt         <= cnt_next;
    rd_idx      <= cnt[IDX_W-1:0];
    refill_pass <= refill_pass_next;
    found       <= found_next;
    bt          <= bt_next;
    ba          <= ba_next;
    bidx        <= bidx_next;
    any_pr      <= any_pr_next;
    res_status  <= res_status_next;
    res_task    <= res_task_next;
    res_ticks   <= res_ticks_next;
    res_refl    <= res_refl_next;
    if (load_out) begin
      out_status <= res_status;
      out_task   <= res_task;
      out_ticks  <= res_ticks;
      out_refl   <= res_refl;
    end
  end

endmodule

### tb/sv/tick_credit_run_queue_tb.sv
// Testbench: directed table and random requests for the tick credit run queue, checked against table or predictor.
`timescale 1ns / 1ps

module tick_credit_run_queue_tb;
  import tcrq_pkg::*;

  localparam int SLOTS     = 16;
  localparam int NDIR      = 25;
  localparam int NRAND     = 1950;
  localparam int IDLE_PCT  = 31;
  localparam int CYC_LIMIT = 400000;

  typedef struct packed {
    func_t             func;
    logic [ID_W-1:0]   task_id;
    logic [TICK_W-1:0] tick_count;
    logic [TICK_W-1:0] task_priority;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   next_task;
    logic [TICK_W-1:0] next_ticks;
    logic              refilled;
  } rsp_t;

  typedef struct packed {
    req_t w;
    bit   known;
    rsp_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic drv_valid = 1'b0;
  req_t drv_word = '0;
  logic rdy_q = 1'b0;
  bit   calm = 1'b0;
  int   fails = 0;
  int   cycles = 0;

  rsp_t pending_rsp[$];

  // shadow run queue
  bit                q_valid [SLOTS];
  logic [TICK_W-1:0] q_ticks [SLOTS];
  logic [TICK_W-1:0] q_prio  [SLOTS];
  logic [ID_W-1:0]   q_age   [SLOTS];
  int                q_count = 0;

  tcrq_in_if  req ();
  tcrq_out_if rsp ();

  assign req.valid         = drv_valid;
  assign req.func          = drv_word.func;
  assign req.task_id       = drv_word.task_id;
  assign req.tick_count    = drv_word.tick_count;
  assign req.task_priority = drv_word.task_priority;
  assign rsp.ready         = rdy_q;

  tick_credit_run_queue #(
    .MAX_TASKS(SLOTS),
    .TICK_BITS(TICK_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  dir_row_t dir_tab [0:NDIR-1] = '{
    '{'{FUNC_PICK, 4'd0,  8'd0,   8'd0},   1'b1, '{STAT_EMPTY,    4'd0,  8'd0,   1'b0}},
    '{'{FUNC_DEQ,  4'd5,  8'd0,   8'd0},   1'b1, '{STAT_BAD,      4'd0,  8'd0,   1'b0}},
    '{'{FUNC_SET,  4'd5,  8'd9,   8'd0},   1'b1, '{STAT_BAD,      4'd0,  8'd0,   1'b0}},
    '{'{FUNC_ENQ,  4'd0,  8'd0,   8'd0},   1'b1, '{STAT_OK,       4'd0,  8'd0,   1'b0}},
    '{'{FUNC_PICK, 4'd0,  8'd0,   8'd0},   1'b1, '{STAT_NOREFILL, 4'd0,  8'd0,   1'b0}},
    '{'{FUNC_ENQ,  4'd0,  8'd1,   8'd1},   1'b1, '{STAT_BAD,      4'd0,  8'd0,   1'b0}},
    '{'{FUNC_ENQ,  4'd15, 8'd255, 8'd255}, 1'b1, '{STAT_OK,       4'd0,  8'd0,   1'b0}},
    '{'{FUNC_PICK, 4'd0,  8'd0,   8'd0},   1'b1, '{STAT_OK,       4'd15, 8'd255, 1'b0}},
    '{'{FUNC_ENQ,  4'd7,  8'd255, 8'd1},   1'b1, '{STAT_OK,       4'd0,  8'd0,   1'b0}},
    '{'{FUNC_PICK, 4'd0,  8'd0,   8'd0},   1'b1, '{STAT_OK,       4'd7,  8'd255, 1'b0}},
    '{'{FUNC_SET,  4'd15, 8'd0,   8'd0},   1'b1, '{STAT_OK,       4'd0,  8'd0,   1'b0}},
    '{'{FUNC_SET,  4'd7,  8'd0,   8'd0},   1'b1, '{STAT_OK,       4'd0,  8'd0,   1'b0}},
    '{'{FUNC_PICK, 4'd0,  8'd0,   8'd0},   1'b1, '{STAT_OK,       4'd15, 8'd255, 1'b1}},
    '{'{FUNC_DEQ,  4'd15, 8'd0,   8'd0},   1'b1, '{STAT_OK,       4'd0,  8'd0,   1'b0}},
    '{'{FUNC_SET,  4'd7,  8'd0,   8'd0},   1'b1, '{STAT_OK,       4'd0,  8'd0,   1'b0}},
    '{'{FUNC_PICK, 4'd0,  8'd0,   8'd0},   1'b1, '{STAT_OK,       4'd7,  8'd1,   1'b1}},
    '{'{FUNC_ENQ,  4'd10, 8'h55,  8'hAA},  1'b0, '0},
    '{'{FUNC_ENQ,  4'd5,  8'hAA,  8'h55},  1'b0, '0},
    '{'{FUNC_SET,  4'd10, 8'hAA,  8'd0},   1'b0, '0},
    '{'{FUNC_PICK, 4'd0,  8'd0,   8'd0},   1'b0, '0},
    '{'{FUNC_DEQ,  4'd7,  8'd0,   8'd0},   1'b0, '0},
    '{'{FUNC_DEQ,  4'd0,  8'd0,   8'd0},   1'b0, '0},
    '{'{FUNC_DEQ,  4'd10, 8'd0,   8'd0},   1'b0, '0},
    '{'{FUNC_DEQ,  4'd5,  8'd0,   8'd0},   1'b0, '0},
    '{'{FUNC_PICK, 4'd0,  8'd0,   8'd0},   1'b1, '{STAT_EMPTY,    4'd0,  8'd0,   1'b0}}
  };

  function automatic int find_best(output logic [TICK_W-1:0] bt);
    int b;
    logic [ID_W-1:0] ba;
    b  = -1;
    bt = '0;
    ba = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (q_valid[i] && (b < 0 || q_ticks[i] > bt || (q_ticks[i] == bt && q_age[i] < ba))) begin
        b  = i;
        bt = q_ticks[i];
        ba = q_age[i];
      end
    end
    return b;
  endfunction

  function automatic rsp_t run_queue_step(req_t w);
    rsp_t o;
    int best;
    logic [TICK_W-1:0] bt;
    logic [ID_W-1:0] age;
    bit any;
    o = '{STAT_OK, '0, '0, 1'b0};
    case (w.func)
      FUNC_PICK: begin
        best = find_best(bt);
        if (best < 0) begin
          o.status = STAT_EMPTY;
        end else begin
          if (bt == 0) begin
            any = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
              if (q_valid[i]) begin
                q_ticks[i] = q_prio[i];
                if (q_prio[i] != 0) any = 1'b1;
              end
            end
            if (any) begin
              o.refilled = 1'b1;
              best = find_best(bt);
            end else begin
              o.status = STAT_NOREFILL;
            end
          end
          if (o.status == STAT_OK) begin
            o.next_task  = best[ID_W-1:0];
            o.next_ticks = bt;
          end
        end
      end
      FUNC_ENQ: begin
        if (q_valid[w.task_id]) begin
          o.status = STAT_BAD;
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (q_valid[i]) q_age[i] = q_age[i] + 1'b1;
          q_valid[w.task_id] = 1'b1;
          q_ticks[w.task_id] = w.tick_count;
          q_prio[w.task_id]  = w.task_priority;
          q_age[w.task_id]   = '0;
          q_count++;
        end
      end
      FUNC_DEQ: begin
        if (!q_valid[w.task_id]) begin
          o.status = STAT_BAD;
        end else begin
          age = q_age[w.task_id];
          q_valid[w.task_id] = 1'b0;
          for (int i = 0; i < SLOTS; i++)
            if (q_valid[i] && q_age[i] > age) q_age[i] = q_age[i] - 1'b1;
          q_count--;
        end
      end
      default: begin
        if (!q_valid[w.task_id]) o.status = STAT_BAD;
        else q_ticks[w.task_id] = w.tick_count;
      end
    endcase
    return o;
  endfunction

  function automatic logic [ID_W-1:0] any_slot(bit present);
    logic [ID_W-1:0] s;
    for (int t = 0; t < 32; t++) begin
      s = ID_W'($urandom_range(0, SLOTS - 1));
      if (q_valid[s] == present) return s;
    end
    return ID_W'($urandom_range(0, SLOTS - 1));
  endfunction

  // zero and small values make ties and refills common
  function automatic logic [TICK_W-1:0] rand_ticks();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return TICK_W'($urandom_range(1, 3));
      default: return TICK_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic req_t rand_word(int k);
    req_t w;
    int r;
    bit drain;
    drain = ((k / 150) % 2) == 1;
    r = $urandom_range(0, 99);
    w.func          = FUNC_PICK;
    w.task_id       = ID_W'($urandom_range(0, SLOTS - 1));
    w.tick_count    = rand_ticks();
    w.task_priority = rand_ticks();
    if (r < 6) begin
      w.func          = func_t'($urandom_range(0, 3));
      w.tick_count    = TICK_W'($urandom_range(0, 255));
      w.task_priority = TICK_W'($urandom_range(0, 255));
    end else if (r < (drain ? 20 : 34)) begin
      w.func    = FUNC_ENQ;
      w.task_id = any_slot(1'b0);
    end else if (r < 52) begin
      w.func    = FUNC_DEQ;
      w.task_id = any_slot(1'b1);
    end else if (r < 76) begin
      w.func = FUNC_PICK;
    end else begin
      w.func    = FUNC_SET;
      w.task_id = any_slot(1'b1);
    end
    return w;
  endfunction

  task automatic send_word(req_t w, bit known, rsp_t typed);
    rsp_t e;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      drv_valid <= 1'b0;
      @(posedge clk);
    end
    drv_valid <= 1'b1;
    drv_word  <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    e = run_queue_step(w);
    if (known) e = typed;
    pending_rsp.push_back(e);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      q_valid[i] = 1'b0;
      q_ticks[i] = '0;
      q_prio[i]  = '0;
      q_age[i]   = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < NDIR; k++)
      send_word(dir_tab[k].w, dir_tab[k].known, dir_tab[k].r);
    for (int k = 0; k < NRAND; k++) begin
      calm = (k >= 900 && k < 1150);
      send_word(rand_word(k), 1'b0, '0);
    end
    calm = 1'b0;
    drv_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk) begin : rsp_check
    rsp_t e;
    if (!rst) begin
      if (rsp.valid && rdy_q) begin
        if (pending_rsp.size() == 0) begin
          $error("response word with none expected");
          fails++;
        end else begin
          e = pending_rsp.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp.status);
            fails++;
          end
          if (rsp.next_task !== e.next_task) begin
            $error("next_task: expected %0d, got %0d", e.next_task, rsp.next_task);
            fails++;
          end
          if (rsp.next_ticks !== e.next_ticks) begin
            $error("next_ticks: expected %0d, got %0d", e.next_ticks, rsp.next_ticks);
            fails++;
          end
          if (rsp.refilled !== e.refilled) begin
            $error("refilled: expected %0d, got %0d", e.refilled, rsp.refilled);
            fails++;
          end
        end
      end
      rdy_q <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
